// ===== src/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg
// Shared types and constants for the character buffer splice engine.
// ----------------------------------------------------------------------------
package cbse_pkg;

    localparam int CAPACITY_DEF = 64;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_OVERWRITE = 3'd2,
        OP_STAGE     = 3'd3,
        OP_REPLACE   = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef struct packed {
        logic load;
        logic check;
        logic read_cap;
        logic start_move;
        logic start_copy;
        logic commit;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic ok;
        logic busy;
    } t_dp_status;

endpackage

// ===== src/cbse_ram.sv =====
// ----------------------------------------------------------------------------
// cbse_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/cbse_datapath.sv =====
// ----------------------------------------------------------------------------
// cbse_datapath
// Buffer stores, lengths, range checks, byte move engine and result register.
// ----------------------------------------------------------------------------
module cbse_datapath
    import cbse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LW       = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_status    o_status,
    input  logic [2:0]    i_op,
    input  logic [LW-1:0] i_position,
    input  logic [LW-1:0] i_remove_count,
    input  logic [7:0]    i_char_in,
    output logic          o_status_bit,
    output logic [LW-1:0] o_length,
    output logic [7:0]    o_char_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [LW:0] CAP_V = (LW + 1)'(CAPACITY);

    logic [2:0]    r_op;
    logic [LW-1:0] r_pos;
    logic [LW-1:0] r_rc;
    logic [7:0]    r_char;
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_slen;

    logic [AW-1:0] r_src;
    logic [AW-1:0] r_dst;
    logic [LW-1:0] r_cnt;
    logic          r_desc;
    logic          r_sel_stage;
    logic          r_wv;
    logic [AW-1:0] r_wa;
    logic          r_wsel;

    logic          r_res_status;
    logic [7:0]    r_res_char;
    logic          r_out_status;
    logic [LW-1:0] r_out_len;
    logic [7:0]    r_out_char;

    logic [LW:0]   len_x, slen_x, pos_x, rc_x;
    logic [LW:0]   newlen, tail, room;
    logic          grow, ok, moving;

    logic          main_we;
    logic [AW-1:0] main_wa;
    logic [7:0]    main_wd;
    logic [AW-1:0] main_ra;
    logic [7:0]    main_rd;
    logic          stage_we;
    logic [7:0]    stage_rd;

    assign len_x  = {1'b0, r_len};
    assign slen_x = {1'b0, r_slen};
    assign pos_x  = {1'b0, r_pos};
    assign rc_x   = {1'b0, r_rc};
    assign room   = len_x - pos_x;
    assign newlen = len_x - rc_x + slen_x;
    assign tail   = room - rc_x;
    assign grow   = (r_slen > r_rc);
    assign moving = (r_cnt != '0);

    always_comb begin
        case (r_op)
            OP_APPEND:                      ok = (len_x < CAP_V);
            OP_DELETE, OP_OVERWRITE, OP_READ: ok = (r_pos < r_len);
            OP_STAGE:                       ok = (slen_x < CAP_V);
            OP_REPLACE:
                ok = (r_pos <= r_len) && (rc_x <= room) && (newlen <= CAP_V);
            default:                        ok = 1'b0;
        endcase
    end

    assign o_status.op   = t_op'(r_op);
    assign o_status.ok   = ok;
    assign o_status.busy = moving || r_wv;

    always_comb begin
        main_we = 1'b0;
        main_wa = r_wa;
        main_wd = r_wsel ? stage_rd : main_rd;
        if (r_wv) begin
            main_we = 1'b1;
        end else if (i_cmd.check && ok && r_op == OP_APPEND) begin
            main_we = 1'b1;
            main_wa = r_len[AW-1:0];
            main_wd = r_char;
        end else if (i_cmd.check && ok && r_op == OP_OVERWRITE) begin
            main_we = 1'b1;
            main_wa = r_pos[AW-1:0];
            main_wd = r_char;
        end
    end

    assign main_ra  = (moving && !r_sel_stage) ? r_src : r_pos[AW-1:0];
    assign stage_we = i_cmd.check && ok && (r_op == OP_STAGE);

    cbse_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (main_wa),
        .i_wdata (main_wd),
        .i_raddr (main_ra),
        .o_rdata (main_rd)
    );

    cbse_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (stage_we),
        .i_waddr (r_slen[AW-1:0]),
        .i_wdata (r_char),
        .i_raddr (r_src),
        .o_rdata (stage_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_slen <= '0;
            r_cnt  <= '0;
            r_wv   <= 1'b0;
        end else begin
            r_wv <= moving;
            if (i_cmd.check && ok && r_op == OP_APPEND) begin
                r_len <= r_len + 1'b1;
            end
            if (i_cmd.check && ok && r_op == OP_STAGE) begin
                r_slen <= r_slen + 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_op == OP_REPLACE) begin
                    r_len  <= newlen[LW-1:0];
                    r_slen <= '0;
                end else begin
                    r_len <= r_len - 1'b1;
                end
            end
            if (i_cmd.start_move) begin
                if (r_op == OP_DELETE) begin
                    r_cnt <= LW'(room - 1'b1);
                end else begin
                    r_cnt <= tail[LW-1:0];
                end
            end else if (i_cmd.start_copy) begin
                r_cnt <= r_slen;
            end else if (moving) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wa   <= r_dst;
        r_wsel <= r_sel_stage;
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_pos  <= i_position;
            r_rc   <= i_remove_count;
            r_char <= i_char_in;
        end
        if (i_cmd.start_move) begin
            r_sel_stage <= 1'b0;
            if (r_op == OP_DELETE) begin
                r_src  <= AW'(pos_x + 1'b1);
                r_dst  <= r_pos[AW-1:0];
                r_desc <= 1'b0;
            end else if (grow) begin
                r_src  <= AW'(len_x - 1'b1);
                r_dst  <= AW'(newlen - 1'b1);
                r_desc <= 1'b1;
            end else begin
                r_src  <= AW'(pos_x + rc_x);
                r_dst  <= AW'(pos_x + slen_x);
                r_desc <= 1'b0;
            end
        end else if (i_cmd.start_copy) begin
            r_sel_stage <= 1'b1;
            r_src       <= '0;
            r_dst       <= r_pos[AW-1:0];
            r_desc      <= 1'b0;
        end else if (moving) begin
            r_src <= r_desc ? r_src - 1'b1 : r_src + 1'b1;
            r_dst <= r_desc ? r_dst - 1'b1 : r_dst + 1'b1;
        end
        if (i_cmd.check) begin
            r_res_status <= !ok;
            r_res_char   <= '0;
        end
        if (i_cmd.read_cap) begin
            r_res_char <= main_rd;
        end
        if (i_cmd.finish) begin
            r_out_status <= r_res_status;
            r_out_len    <= r_len;
            r_out_char   <= r_res_char;
        end
    end

    assign o_status_bit = r_out_status;
    assign o_length     = r_out_len;
    assign o_char_out   = r_out_char;

endmodule

// ===== src/cbse_controller.sv =====
// ----------------------------------------------------------------------------
// cbse_controller
// Operation sequencer and stream handshake control.
// ----------------------------------------------------------------------------
module cbse_controller
    import cbse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_READ  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_COPY  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_DONE;
                if (i_status.ok) begin
                    case (i_status.op)
                        OP_READ: n_state = S_READ;
                        OP_DELETE, OP_REPLACE: begin
                            o_cmd.start_move = 1'b1;
                            n_state          = S_MOVE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_MOVE: begin
                if (!i_status.busy) begin
                    if (i_status.op == OP_REPLACE) begin
                        o_cmd.start_copy = 1'b1;
                        n_state          = S_COPY;
                    end else begin
                        o_cmd.commit = 1'b1;
                        n_state      = S_DONE;
                    end
                end
            end
            S_COPY: begin
                if (!i_status.busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.finish = 1'b1;
                    n_m_valid    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && i_rst_n;
    assign o_m_tvalid = r_m_valid;

endmodule

// ===== src/char_buffer_splice_engine_top.sv =====
// ----------------------------------------------------------------------------
// char_buffer_splice_engine_top
// Byte buffer with staging area: append, delete, overwrite, stage, replace, read.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Append, overwrite, stage, read
// and rejected requests finish without the move engine; a delete shifts the bytes
// after its position down, and a replace shifts the tail and then copies in the
// staging bytes. The move engine shifts or copies one byte per cycle through the
// single write port of the main buffer RAM. The next transaction is taken as soon
// as the result sits in the output register, even while it waits.
module char_buffer_splice_engine_top
    import cbse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LW       = $clog2(CAPACITY + 1),
    parameter int IN_W     = ((2 * LW + 8 + 7) / 8) * 8,
    parameter int OUT_W    = ((LW + 8 + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // position, remove_count, char_in
    input  logic [2:0]       s_axis_tuser,  // op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // length, char_out
    output logic             m_axis_tuser   // status
);

    t_dp_cmd       cmd;
    t_dp_status    status;
    logic          res_status;
    logic [LW-1:0] res_len;
    logic [7:0]    res_char;

    cbse_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    cbse_datapath #(.CAPACITY(CAPACITY), .LW(LW)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (s_axis_tuser),
        .i_position     (s_axis_tdata[LW-1:0]),
        .i_remove_count (s_axis_tdata[2*LW-1:LW]),
        .i_char_in      (s_axis_tdata[2*LW+7:2*LW]),
        .o_status_bit   (res_status),
        .o_length       (res_len),
        .o_char_out     (res_char)
    );

    assign m_axis_tdata = OUT_W'({res_char, res_len});
    assign m_axis_tuser = res_status;

endmodule

// ===== src/cbse_checker.sv =====
// ----------------------------------------------------------------------------
// cbse_checker
// Port-level checks for the splice engine, bound to the top level.
// ----------------------------------------------------------------------------
module cbse_checker
    import cbse_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LW       = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((LW + 8 + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a transaction is in progress");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[LW-1:0]} <= (LW + 1)'(CAPACITY)))
        else $error("length beyond capacity");

    a_reject_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[LW+7:LW] == 8'd0))
        else $error("rejected result carries a byte");

endmodule

bind char_buffer_splice_engine_top cbse_checker #(
    .CAPACITY (CAPACITY),
    .LW       (LW),
    .OUT_W    (OUT_W)
) u_cbse_checker (.*);

// ===== bench/char_buffer_splice_engine_top_test.sv =====
// ----------------------------------------------------------------------------
// char_buffer_splice_engine_top_test
// Self-checking bench for the splice engine. A directed table covers empty
// and rejected requests, the byte extremes and a first splice; random sequences
// then grow and shrink both buffers up to capacity. Typed rows are checked with
// the table, other results with a local prediction of the main and staging buffers.
// ----------------------------------------------------------------------------
module char_buffer_splice_engine_top_test
    import cbse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CAPACITY    = CAPACITY_DEF;
    localparam int         ITEMS       = 900;
    localparam int         HOLD_CYCLES = 400;
    localparam int         DRAIN       = 2 * CAPACITY + 16;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic       ST_DONE     = 1'b0;
    localparam logic       ST_REJECT   = 1'b1;

    typedef enum int unsigned {MIX_GROW, MIX_SHRINK, MIX_BALANCED} t_mix;

    typedef struct packed {
        logic       status;
        logic [6:0] length;
        logic [7:0] char_out;
    } t_result;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] pos;
        logic [6:0] rc;
        logic [7:0] ch;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // position, remove_count, char_in
    logic [2:0]  s_axis_tuser  = '0;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // length, char_out
    logic        m_axis_tuser;         // status

    logic [7:0]  main_buf  [CAPACITY] = '{default: '0};
    logic [7:0]  stage_buf [CAPACITY] = '{default: '0};
    int unsigned main_len  = 0;
    int unsigned stage_len = 0;

    t_result     pending_results [$];
    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 20;
    int unsigned recv_idle_pct = 48;
    bit          hold_request  = 1'b0;

    char_buffer_splice_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_result splice_predict(logic [2:0] op, logic [6:0] pos,
                                               logic [6:0] rc, logic [7:0] ch);
        t_result     res;
        int unsigned tail;
        int unsigned new_len;
        res.status   = ST_REJECT;
        res.char_out = '0;
        case (op)
            OP_APPEND: begin
                if (main_len < CAPACITY) begin
                    main_buf[main_len] = ch;
                    main_len++;
                    res.status = ST_DONE;
                end
            end
            OP_DELETE: begin
                if (pos < main_len) begin
                    for (int i = pos; i + 1 < main_len; i++)
                        main_buf[i] = main_buf[i + 1];
                    main_len--;
                    res.status = ST_DONE;
                end
            end
            OP_OVERWRITE: begin
                if (pos < main_len) begin
                    main_buf[pos] = ch;
                    res.status = ST_DONE;
                end
            end
            OP_STAGE: begin
                if (stage_len < CAPACITY) begin
                    stage_buf[stage_len] = ch;
                    stage_len++;
                    res.status = ST_DONE;
                end
            end
            OP_REPLACE: begin
                if (pos <= main_len && rc <= main_len - pos
                        && main_len - rc + stage_len <= CAPACITY) begin
                    tail    = main_len - pos - rc;
                    new_len = main_len - rc + stage_len;
                    // shift the tail in the direction that never overwrites unread bytes
                    if (stage_len > rc) begin
                        for (int i = tail; i > 0; i--)
                            main_buf[pos + stage_len + i - 1] = main_buf[pos + rc + i - 1];
                    end else begin
                        for (int i = 0; i < tail; i++)
                            main_buf[pos + stage_len + i] = main_buf[pos + rc + i];
                    end
                    for (int i = 0; i < stage_len; i++)
                        main_buf[pos + i] = stage_buf[i];
                    main_len   = new_len;
                    stage_len  = 0;
                    res.status = ST_DONE;
                end
            end
            OP_READ: begin
                if (pos < main_len) begin
                    res.char_out = main_buf[pos];
                    res.status   = ST_DONE;
                end
            end
            default: ;
        endcase
        res.length = main_len[6:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic offer_item(logic [2:0] op, logic [6:0] pos, logic [6:0] rc,
                              logic [7:0] ch, logic typed, t_result typed_res);
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ch, rc, pos};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        res = splice_predict(op, pos, rc, ch);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic offer_random_item(t_mix mix);
        int unsigned pick;
        logic [2:0]  op;
        logic [6:0]  pos;
        logic [6:0]  rc;
        pick = $urandom_range(99);
        if (pick < 2)
            op = pick[0] ? OP_UNUSED_7 : OP_UNUSED_6;
        else if (mix == MIX_GROW)
            op = pick < 40 ? OP_APPEND : pick < 65 ? OP_STAGE : pick < 75 ? OP_OVERWRITE :
                 pick < 85 ? OP_READ : pick < 95 ? OP_REPLACE : OP_DELETE;
        else if (mix == MIX_SHRINK)
            op = pick < 35 ? OP_DELETE : pick < 55 ? OP_REPLACE : pick < 70 ? OP_READ :
                 pick < 80 ? OP_OVERWRITE : pick < 90 ? OP_STAGE : OP_APPEND;
        else
            op = pick < 20 ? OP_APPEND : pick < 35 ? OP_STAGE : pick < 50 ? OP_REPLACE :
                 pick < 65 ? OP_DELETE : pick < 80 ? OP_OVERWRITE : OP_READ;
        // mostly valid positions, now and then anything the field can hold
        if (op == OP_REPLACE) begin
            pos = $urandom_range(99) < 85 ? 7'($urandom_range(main_len)) : 7'($urandom_range(127));
            if (pos <= main_len && $urandom_range(99) < 80)
                rc = 7'($urandom_range(main_len - pos));
            else
                rc = 7'($urandom_range(127));
        end else begin
            if (main_len > 0 && $urandom_range(99) < 88)
                pos = 7'($urandom_range(main_len - 1));
            else
                pos = 7'($urandom_range(127));
            rc = 7'($urandom_range(127));
        end
        offer_item(op, pos, rc, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    initial begin
        int unsigned stall_cnt;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (stall_cnt = 0; stall_cnt < HOLD_CYCLES; stall_cnt++) begin
                    m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none pending", m_axis_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", m_axis_tuser, want.status);
                if (m_axis_tdata[6:0] !== want.length)
                    report_mismatch("length", m_axis_tdata[6:0], want.length);
                if (m_axis_tdata[14:7] !== want.char_out)
                    report_mismatch("char_out", m_axis_tdata[14:7], want.char_out);
            end
        end
    end

    initial begin
        t_row directed_rows [$];
        t_mix mix;
        mix = MIX_GROW;
        directed_rows = '{
            '{OP_READ,      7'd0,   7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd0, 8'h00}},
            '{OP_DELETE,    7'd0,   7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd0, 8'h00}},
            '{OP_OVERWRITE, 7'd0,   7'd0,   8'h55, 1'b1, '{ST_REJECT, 7'd0, 8'h00}},
            '{OP_REPLACE,   7'd1,   7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd0, 8'h00}},
            '{OP_REPLACE,   7'd0,   7'd0,   8'h00, 1'b1, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_APPEND,    7'd0,   7'd0,   8'h00, 1'b1, '{ST_DONE,   7'd1, 8'h00}},
            '{OP_APPEND,    7'd0,   7'd0,   8'hff, 1'b1, '{ST_DONE,   7'd2, 8'h00}},
            '{OP_APPEND,    7'd0,   7'd0,   8'h3c, 1'b1, '{ST_DONE,   7'd3, 8'h00}},
            '{OP_READ,      7'd1,   7'd0,   8'h00, 1'b1, '{ST_DONE,   7'd3, 8'hff}},
            '{OP_READ,      7'd0,   7'd0,   8'h00, 1'b1, '{ST_DONE,   7'd3, 8'h00}},
            '{OP_READ,      7'd3,   7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_READ,      7'd127, 7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_OVERWRITE, 7'd2,   7'd0,   8'ha5, 1'b1, '{ST_DONE,   7'd3, 8'h00}},
            '{OP_UNUSED_6,  7'd127, 7'd127, 8'hff, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_UNUSED_7,  7'd0,   7'd0,   8'h00, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_STAGE,     7'd0,   7'd0,   8'h11, 1'b1, '{ST_DONE,   7'd3, 8'h00}},
            '{OP_STAGE,     7'd0,   7'd0,   8'hee, 1'b1, '{ST_DONE,   7'd3, 8'h00}},
            '{OP_REPLACE,   7'd2,   7'd2,   8'h00, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_REPLACE,   7'd0,   7'd127, 8'h00, 1'b1, '{ST_REJECT, 7'd3, 8'h00}},
            '{OP_REPLACE,   7'd1,   7'd1,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_READ,      7'd2,   7'd0,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_DELETE,    7'd0,   7'd0,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_REPLACE,   7'd0,   7'd0,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_REPLACE,   7'd3,   7'd0,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}},
            '{OP_DELETE,    7'd2,   7'd0,   8'h00, 1'b0, '{ST_DONE,   7'd0, 8'h00}}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].rc,
                       directed_rows[i].ch, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < ITEMS; n++) begin
            if (n == ITEMS / 3) begin
                send_idle_pct = 48;
                recv_idle_pct = 20;
            end else if (n == 2 * ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 40 == 0)
                mix = t_mix'($urandom_range(2));
            // hold the sender until the block has drained
            if (n == ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            if (n == 3 * ITEMS / 4)
                hold_request = 1'b1;
            offer_random_item(mix);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cbse_pkg.sv
src/cbse_ram.sv
src/cbse_datapath.sv
src/cbse_controller.sv
src/char_buffer_splice_engine_top.sv
src/cbse_checker.sv
bench/char_buffer_splice_engine_top_test.sv
